// ===== design/assert_macros.svh =====
// Assertion macros for the ordered map design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an expression is never true at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/omr_pkg.sv =====
// Types and constants of the ordered map with rank lookup.
package omr_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 7;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LOOKUP = 2'd2,
		REQ_RANK   = 2'd3
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_e_t;

	// Write command broadcast to every cell in the execute cycle.
	typedef struct packed {
		logic insert;
		logic remove;
		logic update;
	} cell_cmd_t;

	// Compare results of one cell against the current request.
	typedef struct packed {
		logic lt;
		logic eq;
		logic sel;
	} cell_flag_t;

endpackage

// ===== design/omr_cell.sv =====
// One slot of the sorted row: holds a pair, compares it and shifts with its neighbours.
module omr_cell (
	input  logic                                clk,
	input  logic [omr_pkg::IDX_W-1:0]           idx,
	input  logic [omr_pkg::CNT_W-1:0]           count,
	input  logic signed [omr_pkg::KEY_W-1:0]    req_key,
	input  logic signed [omr_pkg::VAL_W-1:0]    req_value,
	input  logic [omr_pkg::RANK_W-1:0]          req_rank,
	input  omr_pkg::cell_cmd_t                  cmd,
	input  logic                                left_lt,
	input  logic signed [omr_pkg::KEY_W-1:0]    left_key,
	input  logic signed [omr_pkg::VAL_W-1:0]    left_value,
	input  logic signed [omr_pkg::KEY_W-1:0]    right_key,
	input  logic signed [omr_pkg::VAL_W-1:0]    right_value,
	output omr_pkg::cell_flag_t                 flag,
	output logic signed [omr_pkg::KEY_W-1:0]    key_q,
	output logic signed [omr_pkg::VAL_W-1:0]    value_q
);
	import omr_pkg::*;

	logic occupied;

	// The stored pairs always fill the row from slot zero upwards.
	assign occupied = CNT_W'(idx) < count;

	always_comb begin
		flag.lt  = occupied && (key_q < req_key);
		flag.eq  = occupied && (key_q == req_key);
		flag.sel = occupied && (32'(req_rank) == (32'(idx) + 32'd1));
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !flag.lt) begin
			// The first slot not below the key takes the new pair, the rest move up.
			if (left_lt) begin
				key_q   <= req_key;
				value_q <= req_value;
			end else begin
				key_q   <= left_key;
				value_q <= left_value;
			end
		end else if (cmd.remove && !flag.lt) begin
			key_q   <= right_key;
			value_q <= right_value;
		end else if (cmd.update && flag.eq) begin
			value_q <= req_value;
		end
	end

endmodule

// ===== design/omr_pick.sv =====
// Gathers the selected pair out of the row and reports whether one was selected.
module omr_pick (
	input  logic [omr_pkg::CAPACITY-1:0]        eq_v,
	input  logic [omr_pkg::CAPACITY-1:0]        sel_v,
	input  logic                                use_rank,
	input  logic signed [omr_pkg::KEY_W-1:0]    keys [omr_pkg::CAPACITY],
	input  logic signed [omr_pkg::VAL_W-1:0]    values [omr_pkg::CAPACITY],
	output logic                                found,
	output logic signed [omr_pkg::KEY_W-1:0]    pick_key,
	output logic signed [omr_pkg::VAL_W-1:0]    pick_value
);
	import omr_pkg::*;

	logic [CAPACITY-1:0] hit_v;

	assign hit_v = use_rank ? sel_v : eq_v;
	assign found = |hit_v;

	// At most one slot matches, so an AND-OR gather acts as the multiplexer.
	always_comb begin
		pick_key   = '0;
		pick_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_key   = pick_key | (keys[i] & {KEY_W{hit_v[i]}});
			pick_value = pick_value | (values[i] & {VAL_W{hit_v[i]}});
		end
	end

endmodule

// ===== design/ordered_map_with_rank.sv =====
// Top level of the ordered map with rank lookup: request register, cell row and result register.
// An ordered key-value store of 64 pairs held as a sorted row of cells. Every request
// (insert or update, delete, lookup by key, lookup by 1-based rank) gives exactly one
// result. A request is captured in the request register at the accepting edge, and in
// the following cycle every cell compares its key with the request at once and shifts its
// pair to a neighbour or takes the new one, while the result goes into the output register.
// The next request is accepted at the edge where that result is taken, or later if the
// output side stalls. An insert into a full store of a key not yet present is dropped
// with status full; an absent key or a rank of zero or above the count reports not found,
// with zero key and value.
`include "assert_macros.svh"

module ordered_map_with_rank (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [omr_pkg::REQ_W-1:0]           req_type,
	input  logic signed [omr_pkg::KEY_W-1:0]    key,
	input  logic signed [omr_pkg::VAL_W-1:0]    value,
	input  logic [omr_pkg::RANK_W-1:0]          rank_query,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [omr_pkg::STAT_W-1:0]          status,
	output logic signed [omr_pkg::KEY_W-1:0]    out_key,
	output logic signed [omr_pkg::VAL_W-1:0]    out_value
);
	import omr_pkg::*;

	logic                        in_accept;
	logic                        busy_q;
	req_e_t                      req_q;
	logic signed [KEY_W-1:0]     key_q;
	logic signed [VAL_W-1:0]     value_q;
	logic [RANK_W-1:0]           rank_q;
	logic [CNT_W-1:0]            count_q;
	logic                        out_valid_q;
	status_e_t                   status_q;
	logic signed [KEY_W-1:0]     out_key_q;
	logic signed [VAL_W-1:0]     out_value_q;

	cell_cmd_t                   cmd;
	cell_flag_t                  flags [CAPACITY];
	logic [CAPACITY-1:0]         lt_v;
	logic [CAPACITY-1:0]         eq_v;
	logic [CAPACITY-1:0]         sel_v;
	logic signed [KEY_W-1:0]     cell_key [CAPACITY];
	logic signed [VAL_W-1:0]     cell_value [CAPACITY];

	logic                        found;
	logic                        full;
	logic signed [KEY_W-1:0]     pick_key;
	logic signed [VAL_W-1:0]     pick_value;
	status_e_t                   res_status;
	logic signed [KEY_W-1:0]     res_key;
	logic signed [VAL_W-1:0]     res_value;

	// Take a transaction only when no request is executing and the output slot is empty or drains at the same edge.
	assign in_stall  = busy_q | (out_valid_q & out_stall);
	assign in_accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q   <= req_e_t'(req_type);
			key_q   <= key;
			value_q <= value;
			rank_q  <= rank_query;
		end
	end

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    left_lt;
		logic signed [KEY_W-1:0] left_key;
		logic signed [VAL_W-1:0] left_value;
		logic signed [KEY_W-1:0] right_key;
		logic signed [VAL_W-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_key   = '0;
			assign left_value = '0;
		end else begin : g_inner_left
			assign left_lt    = lt_v[i-1];
			assign left_key   = cell_key[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key   = '0;
			assign right_value = '0;
		end else begin : g_inner_right
			assign right_key   = cell_key[i+1];
			assign right_value = cell_value[i+1];
		end

		omr_cell u_cell (
			.clk         (clk),
			.idx         (IDX_W'(i)),
			.count       (count_q),
			.req_key     (key_q),
			.req_value   (value_q),
			.req_rank    (rank_q),
			.cmd         (cmd),
			.left_lt     (left_lt),
			.left_key    (left_key),
			.left_value  (left_value),
			.right_key   (right_key),
			.right_value (right_value),
			.flag        (flags[i]),
			.key_q       (cell_key[i]),
			.value_q     (cell_value[i])
		);

		assign lt_v[i]  = flags[i].lt;
		assign eq_v[i]  = flags[i].eq;
		assign sel_v[i] = flags[i].sel;
	end

	omr_pick u_pick (
		.eq_v       (eq_v),
		.sel_v      (sel_v),
		.use_rank   (req_q == REQ_RANK),
		.keys       (cell_key),
		.values     (cell_value),
		.found      (found),
		.pick_key   (pick_key),
		.pick_value (pick_value)
	);

	assign full = count_q == CNT_W'(CAPACITY);

	always_comb begin
		cmd.insert = busy_q && (req_q == REQ_INSERT) && !found && !full;
		cmd.remove = busy_q && (req_q == REQ_DELETE) && found;
		cmd.update = busy_q && (req_q == REQ_INSERT) && found;

		res_status = ST_MISS;
		res_key    = '0;
		res_value  = '0;
		case (req_q)
			REQ_INSERT: begin
				res_status = (!found && full) ? ST_FULL : ST_OK;
			end
			REQ_DELETE: begin
				res_status = found ? ST_OK : ST_MISS;
			end
			REQ_LOOKUP, REQ_RANK: begin
				if (found) begin
					res_status = ST_OK;
					res_key    = pick_key;
					res_value  = pick_value;
				end
			end
			default: begin
				res_status = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.remove) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_q) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			status_q    <= res_status;
			out_key_q   <= res_key;
			out_value_q <= res_value;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;

	`ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "entry count above capacity")
	`ASSERT_NEVER(a_busy_out_overlap, busy_q && out_valid_q, "execute while a result is held")
	`ASSERT_CLK(a_exec_gives_result, busy_q |=> out_valid_q, "execute cycle gave no result")
	`ASSERT_CLK(a_keys_unique, $onehot0(eq_v), "key stored in more than one slot")
	`ASSERT_CLK(a_row_sorted_prefix, busy_q |-> ((lt_v & (lt_v + CAPACITY'(1))) == '0),
		"slots below the key do not form a prefix")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ordered key-value store with rank lookup.
`timescale 1ns / 100ps

module testbench;
	import omr_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1950;
	localparam int QUIET_TAIL   = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		req_e_t              req;
		logic [KEY_W-1:0]    k;
		logic [VAL_W-1:0]    v;
		logic [RANK_W-1:0]   r;
	} map_req_t;

	typedef struct packed {
		status_e_t           st;
		logic [KEY_W-1:0]    k;
		logic [VAL_W-1:0]    v;
	} map_resp_t;

	typedef struct packed {
		map_req_t            rq;
		logic                typed;
		map_resp_t           rs;
	} stim_row_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic [REQ_W-1:0]          req_type   = '0;
	logic signed [KEY_W-1:0]   key        = '0;
	logic signed [VAL_W-1:0]   value      = '0;
	logic [RANK_W-1:0]         rank_query = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [STAT_W-1:0]         status;
	logic signed [KEY_W-1:0]   out_key;
	logic signed [VAL_W-1:0]   out_value;

	// shadow copy of the store
	logic [KEY_W-1:0]          map_keys [CAPACITY];
	logic [VAL_W-1:0]          map_vals [CAPACITY];
	int                        entry_cnt = 0;

	map_resp_t                 expected_results [$];
	stim_row_t                 directed_rows [$];

	int                        errors      = 0;
	int                        cycle_count = 0;
	int                        checked     = 0;
	int                        sent        = 0;
	int                        full_drops  = 0;
	int                        found_cnt   = 0;
	int                        peak_cnt    = 0;
	int                        stall_left  = 0;
	bit                        calm        = 1'b0;

	ordered_map_with_rank dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.key        (key),
		.value      (value),
		.rank_query (rank_query),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_key    (out_key),
		.out_value  (out_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run exceeded %0d cycles, %0d results outstanding", $time, CYCLE_LIMIT,
			expected_results.size());
		$display("[ordered_map_with_rank] ERROR");
		$finish;
	end

	// Work out the answer to one request and update the shadow store.
	function automatic map_resp_t apply_to_map(map_req_t rq);
		map_resp_t rs;
		int        pos;
		int        j;
		bit        hit;
		rs = '{ST_MISS, '0, '0};
		pos = 0;
		while (pos < entry_cnt && $signed(map_keys[pos]) < $signed(rq.k))
			pos++;
		hit = (pos < entry_cnt) && (map_keys[pos] == rq.k);
		case (rq.req)
			REQ_INSERT: begin
				if (hit) begin
					map_vals[pos] = rq.v;
					rs.st = ST_OK;
				end else if (entry_cnt >= CAPACITY) begin
					rs.st = ST_FULL;
					full_drops++;
				end else begin
					for (j = entry_cnt; j > pos; j--) begin
						map_keys[j] = map_keys[j-1];
						map_vals[j] = map_vals[j-1];
					end
					map_keys[pos] = rq.k;
					map_vals[pos] = rq.v;
					entry_cnt++;
					rs.st = ST_OK;
				end
			end
			REQ_DELETE: begin
				if (hit) begin
					for (j = pos; j < entry_cnt - 1; j++) begin
						map_keys[j] = map_keys[j+1];
						map_vals[j] = map_vals[j+1];
					end
					entry_cnt--;
					rs.st = ST_OK;
				end
			end
			REQ_LOOKUP: begin
				if (hit) begin
					rs = '{ST_OK, map_keys[pos], map_vals[pos]};
					found_cnt++;
				end
			end
			default: begin
				if (rq.r >= 1 && int'(rq.r) <= entry_cnt) begin
					rs = '{ST_OK, map_keys[rq.r-1], map_vals[rq.r-1]};
					found_cnt++;
				end
			end
		endcase
		if (entry_cnt > peak_cnt)
			peak_cnt = entry_cnt;
		return rs;
	endfunction

	// Keys already stored with the given percentage, else keys near zero, extremes or anything at all.
	function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (entry_cnt > 0 && roll < hit_pct)
			return map_keys[$urandom_range(0, entry_cnt - 1)];
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return KEY_W'($urandom_range(0, 80)) - KEY_W'(40);
		if (roll < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0000;
			endcase
		end
		return $urandom();
	endfunction

	task automatic add_row(req_e_t req, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic [RANK_W-1:0] r, logic typed, status_e_t st, logic [KEY_W-1:0] ek,
			logic [VAL_W-1:0] ev);
		directed_rows.push_back('{'{req, k, v, r}, typed, '{st, ek, ev}});
	endtask

	task automatic send_request(map_req_t rq, logic typed, map_resp_t typed_rs);
		map_resp_t rs;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq.req;
		key        <= rq.k;
		value      <= rq.v;
		rank_query <= rq.r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rs = apply_to_map(rq);
		expected_results.push_back(typed ? typed_rs : rs);
		sent++;
	endtask

	// Result side: random stall bursts and the check against the oldest expectation.
	always @(posedge clk) begin
		map_resp_t exp_rs;
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: status %0d key %h value %h",
					$time, status, out_key, out_value);
			end else begin
				exp_rs = expected_results.pop_front();
				checked++;
				if (status !== exp_rs.st || out_key !== exp_rs.k || out_value !== exp_rs.v) begin
					errors++;
					$display("%0t: expected status %0d key %h value %h, got %0d %h %h",
						$time, exp_rs.st, exp_rs.k, exp_rs.v, status, out_key, out_value);
				end
			end
		end
	end

	initial begin
		map_req_t  rq;
		stim_row_t row;
		int        mode;
		int        op_roll;
		int        hit_pct;
		int        ins_lim;
		int        del_lim;
		int        look_lim;

		// empty store
		add_row(REQ_LOOKUP, 32'h0000_0000, 32'h1234_5678, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd1, 1, ST_MISS, '0, '0);
		add_row(REQ_RANK,   32'hffff_ffff, 32'hffff_ffff, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_DELETE, 32'h0000_0005, 32'h0000_0000, 7'd3, 1, ST_MISS, '0, '0);
		// extreme keys and values
		add_row(REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff, 7'd0, 1, ST_OK, '0, '0);
		add_row(REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000, 7'd127, 1, ST_OK, '0, '0);
		add_row(REQ_INSERT, 32'hffff_ffff, 32'h5555_5555, 7'd0, 0, ST_OK, '0, '0);
		add_row(REQ_INSERT, 32'h0000_0000, 32'haaaa_aaaa, 7'd0, 0, ST_OK, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd1, 1, ST_OK,
			32'h8000_0000, 32'h7fff_ffff);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd4, 1, ST_OK,
			32'h7fff_ffff, 32'h8000_0000);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd5, 1, ST_MISS, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd127, 1, ST_MISS, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 7'd0, 1, ST_OK,
			32'h8000_0000, 32'h7fff_ffff);
		// update in place, then deletes present and absent
		add_row(REQ_INSERT, 32'h0000_0000, 32'h0000_007b, 7'd0, 1, ST_OK, '0, '0);
		add_row(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 7'd0, 1, ST_OK,
			32'h0000_0000, 32'h0000_007b);
		add_row(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_DELETE, 32'h7fff_ffff, 32'h0000_0000, 7'd0, 1, ST_OK, '0, '0);
		add_row(REQ_DELETE, 32'h7fff_ffff, 32'h0000_0000, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_LOOKUP, 32'h7fff_ffff, 32'h0000_0000, 7'd0, 1, ST_MISS, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd2, 0, ST_OK, '0, '0);
		add_row(REQ_DELETE, 32'hffff_ffff, 32'h0000_0000, 7'd0, 1, ST_OK, '0, '0);
		add_row(REQ_RANK,   32'h0000_0000, 32'h0000_0000, 7'd2, 0, ST_OK, '0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			send_request(row.rq, row.typed, row.rs);
		end

		// Cycle through growing, mixed and draining phases so that the store
		// fills up, overflows and empties again several times.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = (i / 150) % 3;
			calm = ((i / 80) % 5 == 4) || (i >= RANDOM_ITEMS - QUIET_TAIL);
			case (mode)
				0: begin hit_pct = 25; ins_lim = 75; del_lim = 82; look_lim = 91; end
				1: begin hit_pct = 50; ins_lim = 25; del_lim = 50; look_lim = 75; end
				default: begin hit_pct = 85; ins_lim = 10; del_lim = 75; look_lim = 88; end
			endcase
			op_roll = $urandom_range(0, 99);
			if (op_roll < ins_lim)
				rq.req = REQ_INSERT;
			else if (op_roll < del_lim)
				rq.req = REQ_DELETE;
			else if (op_roll < look_lim)
				rq.req = REQ_LOOKUP;
			else
				rq.req = REQ_RANK;
			rq.k = pick_key(hit_pct);
			rq.v = $urandom();
			if ($urandom_range(0, 9) < 7)
				rq.r = RANK_W'($urandom_range(0, entry_cnt + 1));
			else
				rq.r = RANK_W'($urandom_range(0, 127));
			send_request(rq, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d errors", sent, checked, errors);
		$display("store peaked at %0d pairs; %0d full-store drops, %0d lookup hits",
			peak_cnt, full_drops, found_cnt);
		if (errors == 0)
			$display("[ordered_map_with_rank] OK");
		else
			$display("[ordered_map_with_rank] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/omr_pkg.sv
design/omr_cell.sv
design/omr_pick.sv
design/ordered_map_with_rank.sv
tb/testbench.sv
